[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL. Every property samples on clk and is
// disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define HVD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define HVD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/hvd_pkg.sv]
`default_nettype none

package hvd_pkg;

    localparam int XW  = 34;   // CORDIC x/y width, Q30 with headroom
    localparam int ZW  = 34;   // CORDIC angle width, Q30 radians
    localparam int PW  = 58;   // degree-to-radian product width
    localparam int AW  = 31;   // haversine term, 0 .. 2^30
    localparam int SVW = 61;   // square root radicand width
    localparam int SRW = 62;   // square root working root width
    localparam int SQRT_STEPS = 31;

    typedef logic signed [XW-1:0] cval_t;
    typedef logic signed [ZW-1:0] zval_t;

    typedef struct packed {
        cval_t       x;
        cval_t       y;
        zval_t       z;
        logic [1:0]  quad;
    } rot_t;

    typedef struct packed {
        cval_t x;
        cval_t y;
        zval_t z;
    } vec_t;

    typedef struct packed {
        logic [SVW-1:0] v;
        logic [SRW-1:0] r;
    } sqrt_t;

    localparam logic [1:0] QUAD_NONE = 2'd0;
    localparam logic [1:0] QUAD_POS  = 2'd1;
    localparam logic [1:0] QUAD_NEG  = 2'd2;

    localparam int ATAN_ENTRIES = 40;

    localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
        32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000
    };

    localparam zval_t       HALF_PI_Q30    = 34'sd1686629713;
    localparam cval_t       CORDIC_X0      = 34'sd652032874;
    localparam logic [AW-1:0] ONE_Q30      = 31'd1073741824;
    localparam logic signed [23:0] DEG_TO_RAD_Q52 = 24'sd7860264;
    localparam logic signed [33:0] HALF_CIRCLE_UNITS = 34'sd1800000000;
    localparam logic signed [33:0] FULL_CIRCLE_UNITS = 34'sd3600000000;
    localparam logic [22:0] DEFAULT_RADIUS_M = 23'd6371000;
    localparam logic [34:0] OUT_MAX = 35'h7_FFFF_FFFF;

    function automatic zval_t atan_at(input int i);
        zval_t res;
        res = '0;
        if (i < ATAN_ENTRIES)
        begin
            res = {{(ZW-32){1'b0}}, ATAN_Q30[i]};
        end
        return res;
    endfunction

    // Q30 product, rounded half up
    function automatic cval_t mul_q30(input cval_t a, input cval_t b);
        logic signed [2*XW-1:0] p;
        p = a * b;
        p = p + (2*XW)'(64'sd536870912);
        return cval_t'(p >>> 30);
    endfunction

endpackage

`default_nettype wire

[rtl/haversine_distance.sv]
// Great-circle distance between two points on a sphere, fully pipelined.
//
// Input item: start pulses with first/second latitude and longitude
// (signed, 1e-7 degree). busy is always low, so an item is taken on every
// cycle that start is high: one item per clock, sustained.
// Result: done is high for exactly one cycle with distance_mm valid; the
// receiver cannot hold it off and none is needed, since nothing waits.
// On the way to done an item passes the input and multiply registers, the
// four parallel rotation CORDIC chains, the two 31-cell square root chains,
// the vectoring CORDIC chain and the scaling registers, one register per cell.
// Configuration: cfg_valid/cfg_ready/cfg_data write the sphere radius in
// metres; cfg_ready is always high. Write it only while no item is in
// flight. Reset returns the radius to 6371000 m and drops all items in
// flight; there is no clearing pass.
`default_nettype none

`include "assert_macros.svh"

module haversine_distance #(
    parameter int CORDIC_STAGES = 24
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output wire logic               busy,
    input  wire logic signed [30:0] first_latitude,
    input  wire logic signed [31:0] first_longitude,
    input  wire logic signed [30:0] second_latitude,
    input  wire logic signed [31:0] second_longitude,
    output wire logic               done,
    output wire logic [34:0]        distance_mm,
    input  wire logic               cfg_valid,
    output wire logic               cfg_ready,
    input  wire logic [22:0]        cfg_data
);

    localparam int N    = CORDIC_STAGES;
    localparam int LAT  = 2 * N + 43;
    localparam int ST_A = N + 7;   // stage that holds the clamped haversine term

    // ---------------------------------------------------------------
    // Control: valid marks travel alongside the data pipeline.
    // ---------------------------------------------------------------
    logic             accept;
    logic [LAT-1:0]   vld_reg, vld_next;
    logic [22:0]      radius_reg, radius_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign vld_next  = {vld_reg[LAT-2:0], accept};

    always_comb
    begin
        radius_next = radius_reg;
        if (cfg_valid && cfg_ready)
        begin
            radius_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            radius_reg <= hvd_pkg::DEFAULT_RADIUS_M;
        end
        else
        begin
            vld_reg    <= vld_next;
            radius_reg <= radius_next;
        end
    end

    // ---------------------------------------------------------------
    // Front end: differences, longitude wrap, degree to radian.
    // ---------------------------------------------------------------
    logic signed [30:0] lat1_reg, lat2_reg, lat1_s1_reg, lat2_s1_reg;
    logic signed [31:0] dlat_reg, dlat_s1_reg, dlon_s1_reg;
    logic signed [32:0] dlon_reg;
    logic signed [33:0] dlon_wrap;
    logic signed [hvd_pkg::PW-1:0] prod_reg [4];
    logic signed [hvd_pkg::PW-1:0] prod_next [4];

    always_comb
    begin
        // hold the longitude difference inside [-180, 180) degrees
        dlon_wrap = 34'(dlon_reg);
        if (dlon_wrap >= hvd_pkg::HALF_CIRCLE_UNITS)
        begin
            dlon_wrap = dlon_wrap - hvd_pkg::FULL_CIRCLE_UNITS;
        end
        else if (dlon_wrap < -hvd_pkg::HALF_CIRCLE_UNITS)
        begin
            dlon_wrap = dlon_wrap + hvd_pkg::FULL_CIRCLE_UNITS;
        end
        prod_next[0] = hvd_pkg::PW'(dlat_s1_reg) * hvd_pkg::PW'(hvd_pkg::DEG_TO_RAD_Q52);
        prod_next[1] = hvd_pkg::PW'(lat1_s1_reg) * hvd_pkg::PW'(hvd_pkg::DEG_TO_RAD_Q52);
        prod_next[2] = hvd_pkg::PW'(lat2_s1_reg) * hvd_pkg::PW'(hvd_pkg::DEG_TO_RAD_Q52);
        prod_next[3] = hvd_pkg::PW'(dlon_s1_reg) * hvd_pkg::PW'(hvd_pkg::DEG_TO_RAD_Q52);
    end

    always_ff @(posedge clk)
    begin
        lat1_reg    <= first_latitude;
        lat2_reg    <= second_latitude;
        dlat_reg    <= 32'(second_latitude) - 32'(first_latitude);
        dlon_reg    <= 33'(second_longitude) - 33'(first_longitude);
        lat1_s1_reg <= lat1_reg;
        lat2_s1_reg <= lat2_reg;
        dlat_s1_reg <= dlat_reg;
        dlon_s1_reg <= dlon_wrap[31:0];
        prod_reg    <= prod_next;
    end

    // Q52 product to Q30 radians, round half up; halves take one more bit.
    function automatic hvd_pkg::zval_t to_rad(input logic signed [hvd_pkg::PW-1:0] p,
                                              input logic half);
        logic signed [hvd_pkg::PW-1:0] t;
        if (half)
        begin
            t = (p + hvd_pkg::PW'(64'sd4194304)) >>> 23;
        end
        else
        begin
            t = (p + hvd_pkg::PW'(64'sd2097152)) >>> 22;
        end
        return hvd_pkg::zval_t'(t);
    endfunction

    // Pre-rotate by a quarter turn to keep the CORDIC in range.
    function automatic hvd_pkg::rot_t pre_rot(input hvd_pkg::zval_t ang);
        hvd_pkg::rot_t r;
        r.x = hvd_pkg::CORDIC_X0;
        r.y = '0;
        if (ang > hvd_pkg::HALF_PI_Q30)
        begin
            r.z    = ang - hvd_pkg::HALF_PI_Q30;
            r.quad = hvd_pkg::QUAD_POS;
        end
        else if (ang < -hvd_pkg::HALF_PI_Q30)
        begin
            r.z    = ang + hvd_pkg::HALF_PI_Q30;
            r.quad = hvd_pkg::QUAD_NEG;
        end
        else
        begin
            r.z    = ang;
            r.quad = hvd_pkg::QUAD_NONE;
        end
        return r;
    endfunction

    function automatic hvd_pkg::cval_t sin_of(input hvd_pkg::rot_t r);
        hvd_pkg::cval_t s;
        unique case (r.quad)
            hvd_pkg::QUAD_POS: s = r.x;
            hvd_pkg::QUAD_NEG: s = -r.x;
            default:           s = r.y;
        endcase
        return s;
    endfunction

    function automatic hvd_pkg::cval_t cos_of(input hvd_pkg::rot_t r);
        hvd_pkg::cval_t c;
        unique case (r.quad)
            hvd_pkg::QUAD_POS: c = -r.y;
            hvd_pkg::QUAD_NEG: c = r.y;
            default:           c = r.x;
        endcase
        return c;
    endfunction

    // ---------------------------------------------------------------
    // Four rotation chains: half dlat, lat1, lat2, half dlon.
    // ---------------------------------------------------------------
    hvd_pkg::rot_t rot_reg [4];
    hvd_pkg::rot_t rot_c   [4][N+1];

    always_ff @(posedge clk)
    begin
        rot_reg[0] <= pre_rot(to_rad(prod_reg[0], 1'b1));
        rot_reg[1] <= pre_rot(to_rad(prod_reg[1], 1'b0));
        rot_reg[2] <= pre_rot(to_rad(prod_reg[2], 1'b0));
        rot_reg[3] <= pre_rot(to_rad(prod_reg[3], 1'b1));
    end

    for (genvar ch = 0; ch < 4; ch++)
    begin : g_rot
        assign rot_c[ch][0] = rot_reg[ch];
        for (genvar k = 0; k < N; k++)
        begin : g_cell
            hvd_rot_cell #(
                .STAGE (k)
            ) u_cell (
                .clk (clk),
                .d   (rot_c[ch][k]),
                .q   (rot_c[ch][k+1])
            );
        end
    end

    // ---------------------------------------------------------------
    // Haversine term a = sin^2(dlat/2) + cos1*cos2*sin^2(dlon/2).
    // ---------------------------------------------------------------
    hvd_pkg::cval_t sdlat_reg, c1_reg, c2_reg, sdlon_reg;
    hvd_pkg::cval_t sq_lat_reg, sq_lat2_reg, c12_reg, hav_reg, term_reg;
    logic signed [hvd_pkg::XW:0] a_sum;
    logic [hvd_pkg::AW-1:0]      a_reg, a_next;

    always_comb
    begin
        a_sum = (hvd_pkg::XW+1)'(sq_lat2_reg) + (hvd_pkg::XW+1)'(term_reg);
        // clamp to [0, 1]
        if (a_sum < 0)
        begin
            a_next = '0;
        end
        else if (a_sum > (hvd_pkg::XW+1)'(hvd_pkg::ONE_Q30))
        begin
            a_next = hvd_pkg::ONE_Q30;
        end
        else
        begin
            a_next = a_sum[hvd_pkg::AW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        sdlat_reg   <= sin_of(rot_c[0][N]);
        c1_reg      <= cos_of(rot_c[1][N]);
        c2_reg      <= cos_of(rot_c[2][N]);
        sdlon_reg   <= sin_of(rot_c[3][N]);
        sq_lat_reg  <= hvd_pkg::mul_q30(sdlat_reg, sdlat_reg);
        c12_reg     <= hvd_pkg::mul_q30(c1_reg, c2_reg);
        hav_reg     <= hvd_pkg::mul_q30(sdlon_reg, sdlon_reg);
        sq_lat2_reg <= sq_lat_reg;
        term_reg    <= hvd_pkg::mul_q30(c12_reg, hav_reg);
        a_reg       <= a_next;
    end

    // ---------------------------------------------------------------
    // Square roots of a and 1-a, one result bit per cell.
    // ---------------------------------------------------------------
    hvd_pkg::sqrt_t sqy [hvd_pkg::SQRT_STEPS+1];
    hvd_pkg::sqrt_t sqx [hvd_pkg::SQRT_STEPS+1];
    logic [hvd_pkg::AW-1:0] one_minus_a;

    assign one_minus_a = hvd_pkg::ONE_Q30 - a_reg;
    assign sqy[0]      = '{v: {a_reg, 30'd0}, r: '0};
    assign sqx[0]      = '{v: {one_minus_a, 30'd0}, r: '0};

    for (genvar k = 0; k < hvd_pkg::SQRT_STEPS; k++)
    begin : g_sqrt
        hvd_sqrt_cell #(
            .STEP (k)
        ) u_sqy (
            .clk (clk),
            .d   (sqy[k]),
            .q   (sqy[k+1])
        );
        hvd_sqrt_cell #(
            .STEP (k)
        ) u_sqx (
            .clk (clk),
            .d   (sqx[k]),
            .q   (sqx[k+1])
        );
    end

    // ---------------------------------------------------------------
    // Vectoring chain: central angle / 2 = atan2(sqrt(a), sqrt(1-a)).
    // ---------------------------------------------------------------
    hvd_pkg::vec_t vec_c [N+1];

    assign vec_c[0] = '{x: {3'd0, sqx[hvd_pkg::SQRT_STEPS].r[30:0]},
                        y: {3'd0, sqy[hvd_pkg::SQRT_STEPS].r[30:0]},
                        z: '0};

    for (genvar k = 0; k < N; k++)
    begin : g_vec
        hvd_vec_cell #(
            .STAGE (k)
        ) u_cell (
            .clk (clk),
            .d   (vec_c[k]),
            .q   (vec_c[k+1])
        );
    end

    // ---------------------------------------------------------------
    // Scale by radius: mm = floor(R*c)*1000 + round(frac*1000).
    // ---------------------------------------------------------------
    logic [32:0] z_reg;
    logic [56:0] mm_prod_reg;
    logic [36:0] qk_reg;
    logic [39:0] frac_full;
    logic [9:0]  frac_reg;
    logic [37:0] mm_sum;
    logic [34:0] out_reg, out_next;

    assign frac_full = {10'd0, mm_prod_reg[29:0]} * 40'd1000 + 40'd536870912;
    assign mm_sum    = {1'b0, qk_reg} + {28'd0, frac_reg};

    always_comb
    begin
        if (mm_sum > {3'd0, hvd_pkg::OUT_MAX})
        begin
            out_next = hvd_pkg::OUT_MAX;
        end
        else
        begin
            out_next = mm_sum[34:0];
        end
    end

    always_ff @(posedge clk)
    begin
        // drop a negative angle to zero
        z_reg       <= vec_c[N].z[hvd_pkg::ZW-1] ? '0 : vec_c[N].z[32:0];
        mm_prod_reg <= {34'd0, radius_reg} * {23'd0, z_reg, 1'b0};
        qk_reg      <= {10'd0, mm_prod_reg[56:30]} * 37'd1000;
        frac_reg    <= frac_full[39:30];
        out_reg     <= out_next;
    end

    assign done        = vld_reg[LAT-1];
    assign distance_mm = out_reg;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `HVD_ASSERT_IMP(a_done_has_item, done, $past(accept, LAT), "result without an item")
    `HVD_ASSERT_NXT(a_item_gives_done, vld_reg[LAT-2], vld_reg[LAT-1], "item lost in pipeline")
    `HVD_ASSERT_IMP(a_hav_range, vld_reg[ST_A], a_reg <= hvd_pkg::ONE_Q30, "haversine term out of range")
    `HVD_ASSERT_NXT(a_cfg_write, cfg_valid && cfg_ready, radius_reg == $past(cfg_data), "radius write lost")

endmodule

`default_nettype wire

[rtl/hvd_rot_cell.sv]
`default_nettype none

module hvd_rot_cell #(
    parameter int STAGE = 0
) (
    input  wire logic          clk,
    input  var  hvd_pkg::rot_t d,
    output var  hvd_pkg::rot_t q
);

    localparam hvd_pkg::zval_t ANG = hvd_pkg::atan_at(STAGE);

    hvd_pkg::rot_t  q_reg, q_next;
    hvd_pkg::cval_t xs, ys, dx, dy;
    hvd_pkg::zval_t zs;

    always_comb
    begin
        xs = d.x;
        ys = d.y;
        zs = d.z;
        dx = ys >>> STAGE;
        dy = xs >>> STAGE;
        q_next.quad = d.quad;
        // rotate toward zero residual angle
        if (zs >= 0)
        begin
            q_next.x = xs - dx;
            q_next.y = ys + dy;
            q_next.z = zs - ANG;
        end
        else
        begin
            q_next.x = xs + dx;
            q_next.y = ys - dy;
            q_next.z = zs + ANG;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

`default_nettype wire

[rtl/hvd_vec_cell.sv]
`default_nettype none

module hvd_vec_cell #(
    parameter int STAGE = 0
) (
    input  wire logic          clk,
    input  var  hvd_pkg::vec_t d,
    output var  hvd_pkg::vec_t q
);

    localparam hvd_pkg::zval_t ANG = hvd_pkg::atan_at(STAGE);

    hvd_pkg::vec_t  q_reg, q_next;
    hvd_pkg::cval_t xs, ys, dx, dy;
    hvd_pkg::zval_t zs;

    always_comb
    begin
        xs = d.x;
        ys = d.y;
        zs = d.z;
        dx = ys >>> STAGE;
        dy = xs >>> STAGE;
        // drive y toward zero, accumulate the angle
        if (ys >= 0)
        begin
            q_next.x = xs + dx;
            q_next.y = ys - dy;
            q_next.z = zs + ANG;
        end
        else
        begin
            q_next.x = xs - dx;
            q_next.y = ys + dy;
            q_next.z = zs - ANG;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

`default_nettype wire

[rtl/hvd_sqrt_cell.sv]
`default_nettype none

module hvd_sqrt_cell #(
    parameter int STEP = 0
) (
    input  wire logic           clk,
    input  var  hvd_pkg::sqrt_t d,
    output var  hvd_pkg::sqrt_t q
);

    localparam logic [hvd_pkg::SRW-1:0] BIT =
        hvd_pkg::SRW'(1) << (2 * (hvd_pkg::SQRT_STEPS - 1 - STEP));

    hvd_pkg::sqrt_t q_reg, q_next;
    logic [hvd_pkg::SRW-1:0] trial;

    always_comb
    begin
        trial = d.r + BIT;
        // one result bit: subtract the trial value where it fits
        if ({1'b0, d.v} >= trial)
        begin
            q_next.v = d.v - trial[hvd_pkg::SVW-1:0];
            q_next.r = (d.r >> 1) + BIT;
        end
        else
        begin
            q_next.v = d.v;
            q_next.r = d.r >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

`default_nettype wire

[tb/tb.sv]
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAGES = 24;
    localparam int LATENCY = 2 * STAGES + 43;
    localparam int WATCHDOG_LIMIT = 20 * LATENCY + 2000;

    localparam longint HALF_CIRCLE = 64'sd1800000000;
    localparam longint FULL_CIRCLE = 64'sd3600000000;
    localparam longint DEG_RAD_Q52 = 64'sd7860264;
    localparam longint PI_HALF_Q30 = 64'sd1686629713;
    localparam longint X_START     = 64'sd652032874;
    localparam longint UNIT_Q30    = 64'sd1073741824;
    localparam longint DIST_MAX    = 64'sd34359738367;

    // one point pair
    typedef struct {
        logic signed [30:0] lat1;
        logic signed [31:0] lon1;
        logic signed [30:0] lat2;
        logic signed [31:0] lon2;
    } point_pair_t;

    // Distance predictor: integer reproduction of the fixed-point datapath.
    class distance_scoreboard;
        logic [34:0] pending_mm[$];
        logic [22:0] radius_m;
        int          mismatches;

        function new();
            radius_m = hvd_pkg::DEFAULT_RADIUS_M;
            mismatches = 0;
        endfunction

        function longint rad_q30(longint units, int shift);
            longint p;
            p = units * DEG_RAD_Q52;
            return (p + (64'sd1 <<< (shift - 1))) >>> shift;
        endfunction

        function longint atan_entry(int i);
            return (i < hvd_pkg::ATAN_ENTRIES) ? longint'(hvd_pkg::ATAN_Q30[i]) : 64'sd0;
        endfunction

        function longint qmul(longint a, longint b);
            return (a * b + (64'sd1 <<< 29)) >>> 30;
        endfunction

        function void rotate(longint ang, output longint s, output longint c);
            longint x, y, z, t, dx, dy;
            int quad;
            x = X_START;
            y = 0;
            quad = 0;
            if (ang > PI_HALF_Q30)
            begin
                z = ang - PI_HALF_Q30;
                quad = 1;
            end
            else if (ang < -PI_HALF_Q30)
            begin
                z = ang + PI_HALF_Q30;
                quad = -1;
            end
            else
            begin
                z = ang;
            end
            for (int i = 0; i < STAGES; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x -= dx; y += dy; z -= atan_entry(i);
                end
                else
                begin
                    x += dx; y -= dy; z += atan_entry(i);
                end
            end
            if (quad == 1)
            begin
                t = x; x = -y; y = t;
            end
            else if (quad == -1)
            begin
                t = x; x = y; y = -t;
            end
            s = y;
            c = x;
        endfunction

        function longint floor_sqrt(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b >>= 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end
                else
                begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return longint'(r);
        endfunction

        function logic [34:0] distance(point_pair_t p);
            longint dlat, dlon, s, c, c1, c2, hav, a, x, y, z, dx, dy;
            longint unsigned prod, q, r, mm;
            dlat = longint'(p.lat2) - longint'(p.lat1);
            dlon = longint'(p.lon2) - longint'(p.lon1);
            if (dlon >= HALF_CIRCLE)
                dlon -= FULL_CIRCLE;
            if (dlon < -HALF_CIRCLE)
                dlon += FULL_CIRCLE;
            rotate(rad_q30(dlat, 23), s, c);
            a = qmul(s, s);
            rotate(rad_q30(longint'(p.lat1), 22), s, c1);
            rotate(rad_q30(longint'(p.lat2), 22), s, c2);
            rotate(rad_q30(dlon, 23), s, c);
            hav = qmul(s, s);
            a += qmul(qmul(c1, c2), hav);
            if (a < 0)
                a = 0;
            if (a > UNIT_Q30)
                a = UNIT_Q30;
            y = floor_sqrt(longint'(a) <<< 30);
            x = floor_sqrt((UNIT_Q30 - a) <<< 30);
            z = 0;
            for (int i = 0; i < STAGES; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0)
                begin
                    x += dx; y -= dy; z += atan_entry(i);
                end
                else
                begin
                    x -= dx; y += dy; z -= atan_entry(i);
                end
            end
            if (z < 0)
                z = 0;
            prod = longint'(radius_m) * (z * 2);
            q = prod >> 30;
            r = prod & ((64'd1 << 30) - 1);
            mm = q * 1000 + ((r * 1000 + (64'd1 << 29)) >> 30);
            if (mm > DIST_MAX)
                mm = DIST_MAX;
            return mm[34:0];
        endfunction

        function void note_pair(point_pair_t p);
            pending_mm.push_back(distance(p));
        endfunction

        function void check_distance(logic [34:0] got);
            logic [34:0] want;
            if (pending_mm.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected distance_mm %0d", got);
                return;
            end
            want = pending_mm.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("distance_mm mismatch: expected %0d got %0d", want, got);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    wire                busy;
    logic signed [30:0] first_latitude;
    logic signed [31:0] first_longitude;
    logic signed [30:0] second_latitude;
    logic signed [31:0] second_longitude;
    wire                done;
    wire [34:0]         distance_mm;
    logic               cfg_valid;
    wire                cfg_ready;
    logic [22:0]        cfg_data;

    distance_scoreboard board;
    int idle_pct;
    int quiet_cycles;

    haversine_distance #(.CORDIC_STAGES(STAGES)) uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .first_latitude   (first_latitude),
        .first_longitude  (first_longitude),
        .second_latitude  (second_latitude),
        .second_longitude (second_longitude),
        .done             (done),
        .distance_mm      (distance_mm),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Note accepted items and check results at the same edge the block sees.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                board.note_pair('{first_latitude, first_longitude,
                                  second_latitude, second_longitude});
            if (done)
                board.check_distance(distance_mm);
        end
    end

    // Watchdog: count cycles with no accepted item, result or write.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Hold start until the block takes the item; keep start high across
    // back-to-back items and lower it only when the sender goes idle.
    task automatic send_pair(point_pair_t p);
        while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start            <= 1'b1;
        first_latitude   <= p.lat1;
        first_longitude  <= p.lon1;
        second_latitude  <= p.lat2;
        second_longitude <= p.lon2;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic release_start();
        start <= 1'b0;
        @(posedge clk);
    endtask

    // Drain the pipeline, then write the radius while nothing is in flight.
    task automatic drain();
        int waited;
        release_start();
        waited = 0;
        while (board.pending_mm.size() != 0 && waited < 4 * LATENCY)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4)
            @(posedge clk);
    endtask

    task automatic write_radius(logic [22:0] meters);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= meters;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        board.radius_m = meters;
        @(posedge clk);
    endtask

    function automatic logic signed [30:0] any_lat(bit wide);
        if (wide)
            return 31'($urandom);
        return 31'($signed($urandom_range(1800000000, 0)) - 32'sd900000000);
    endfunction

    function automatic logic signed [31:0] any_lon(bit wide);
        if (wide)
            return $urandom;
        return 32'(longint'($urandom_range(32'd3600000000, 0)) - 64'sd1800000000);
    endfunction

    function automatic point_pair_t random_pair();
        point_pair_t p;
        int kind;
        kind = $urandom_range(9, 0);
        // mostly in-range points, some nearby pairs, a few raw bit patterns
        p.lat1 = any_lat(kind == 0);
        p.lon1 = any_lon(kind == 0);
        if (kind >= 7)
        begin
            p.lat2 = p.lat1 + $signed(31'($urandom_range(20000, 0))) - 31'sd10000;
            p.lon2 = p.lon1 + $signed(32'($urandom_range(20000, 0))) - 32'sd10000;
        end
        else
        begin
            p.lat2 = any_lat(kind == 0);
            p.lon2 = any_lon(kind == 0);
        end
        return p;
    endfunction

    task automatic random_phase(int count);
        for (int n = 0; n < count; n++)
            send_pair(random_pair());
    endtask

    initial
    begin
        point_pair_t directed[$];
        board = new();
        rst_n            = 1'b0;
        start            = 1'b0;
        first_latitude   = '0;
        first_longitude  = '0;
        second_latitude  = '0;
        second_longitude = '0;
        cfg_valid        = 1'b0;
        cfg_data         = '0;
        idle_pct         = 0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // field extremes, longitude wrap both ways, poles, antipodes,
        // latitudes beyond 90 degrees, raw extreme bit patterns
        directed.push_back('{31'sd0, 32'sd0, 31'sd0, 32'sd0});
        directed.push_back('{31'sd900000000, 32'sd0, -31'sd900000000, 32'sd0});
        directed.push_back('{31'sd0, -32'sd1800000000, 31'sd0, 32'sd1800000000});
        directed.push_back('{31'sd0, 32'sd1800000000, 31'sd0, -32'sd1800000000});
        directed.push_back('{31'sd0, 32'sd0, 31'sd0, 32'sd1800000000});
        directed.push_back('{31'sd0, -32'sd900000000, 31'sd0, 32'sd900000000});
        directed.push_back('{31'sd0, 32'sd1799999999, 31'sd0, -32'sd1800000000});
        directed.push_back('{31'sd0, 32'sd0, 31'sd0, 32'sd1});
        directed.push_back('{31'sd485000000, 32'sd23000000, 31'sd407000000, -32'sd740000000});
        directed.push_back('{-31'sd338000000, 32'sd1512000000, 31'sd515000000, -32'sd1000000});
        directed.push_back('{31'h3FFFFFFF, 32'h7FFFFFFF, 31'h40000000, 32'h80000000});
        directed.push_back('{31'h40000000, 32'h80000000, 31'h3FFFFFFF, 32'h7FFFFFFF});
        directed.push_back('{31'h7FFFFFFF, 32'hFFFFFFFF, 31'h0, 32'h0});
        directed.push_back('{31'sd1070000000, 32'sd0, -31'sd1070000000, 32'sd0});
        directed.push_back('{31'sd450000000, 32'sd0, -31'sd450000000, 32'sd1800000000});
        foreach (directed[i])
            send_pair(directed[i]);

        // largest radius: antipodes give the longest distance, which still fits the output
        write_radius(23'd8388607);
        foreach (directed[i])
            send_pair(directed[i]);
        write_radius(23'd1);
        send_pair(directed[1]);
        send_pair(directed[4]);

        write_radius(hvd_pkg::DEFAULT_RADIUS_M);
        idle_pct = 0;
        random_phase(150);
        write_radius(23'($urandom_range(8388607, 1)));
        idle_pct = 87;
        random_phase(120);
        write_radius(23'd8388607);
        idle_pct = 10;
        random_phase(120);
        write_radius(23'd1);
        idle_pct = 0;
        random_phase(60);
        write_radius(23'($urandom_range(8388607, 1)));
        idle_pct = 87;
        random_phase(50);

        drain();
        repeat (LATENCY + 10)
            @(posedge clk);
        if (board.mismatches == 0 && board.pending_mm.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

`default_nettype wire

[files.f]
+incdir+rtl
rtl/hvd_pkg.sv
rtl/hvd_rot_cell.sv
rtl/hvd_vec_cell.sv
rtl/hvd_sqrt_cell.sv
rtl/haversine_distance.sv
tb/tb.sv
